/* rtl/core/linear_ar_asr_envelope_top_assert.svh */
// Assertion macros used by the envelope core RTL.
// With SYNTHESIS defined, the macros expand to nothing.
`ifndef LINEAR_AR_ASR_ENVELOPE_TOP_ASSERT_SVH
`define LINEAR_AR_ASR_ENVELOPE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// The property must hold on every clock edge outside reset.
`define ARENV_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("envelope assertion failed");

// The condition must never be true outside reset.
`define ARENV_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("envelope forbidden condition seen");

`else

`define ARENV_ASSERT(label, clk, rst, prop)
`define ARENV_ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

/* rtl/core/arenv_pkg.sv */
`timescale 1ns / 1ps

package arenv_pkg;

  localparam int FRAC_BITS = 24;
  localparam int LEVEL_W   = FRAC_BITS + 2;
  localparam int STEP_W    = FRAC_BITS + 1;
  localparam int CFG_IDX_W = 2;

  typedef logic signed [LEVEL_W-1:0] level_t;
  typedef logic [STEP_W-1:0]         step_t;
  typedef logic [1:0]                phase_t;
  typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;

  // Phase codes
  localparam phase_t PH_IDLE    = 2'd0;
  localparam phase_t PH_ATTACK  = 2'd1;
  localparam phase_t PH_SUSTAIN = 2'd2;
  localparam phase_t PH_RELEASE = 2'd3;

  // Register indexes
  localparam cfg_idx_t CFG_MODE    = 2'd0;
  localparam cfg_idx_t CFG_ATTACK  = 2'd1;
  localparam cfg_idx_t CFG_RELEASE = 2'd2;

  localparam step_t STEP_RESET = STEP_W'(349);

  // Full scale, 1.0 in Q2.FRAC_BITS
  localparam level_t LEVEL_ONE = {{(LEVEL_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam level_t LEVEL_MAX = {1'b0, {(LEVEL_W-1){1'b1}}};
  localparam level_t LEVEL_MIN = {1'b1, {(LEVEL_W-1){1'b0}}};

  typedef struct packed {
    logic  mode;
    step_t attack_step;
    step_t release_step;
  } cfg_t;

  typedef struct packed {
    level_t level;
    phase_t phase;
  } result_t;

endpackage

/* rtl/core/arenv_if.sv */
`timescale 1ns / 1ps

interface arenv_in_if;
  logic valid;
  logic ready;
  logic gate;

  modport source (output valid, output gate, input ready);
  modport sink (input valid, input gate, output ready);
endinterface

interface arenv_out_if;
  import arenv_pkg::*;
  logic   valid;
  logic   ready;
  level_t level;
  phase_t phase;

  modport source (output valid, output level, output phase, input ready);
  modport sink (input valid, input level, input phase, output ready);
endinterface

interface arenv_cfg_if;
  import arenv_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  step_t    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/core/arenv_cfg.sv */
`timescale 1ns / 1ps

module arenv_cfg (
  input  logic           clk,
  input  logic           rst,
  arenv_cfg_if.sink      cfg_ch,
  output arenv_pkg::cfg_t cfg
);
  import arenv_pkg::*;

  logic  mode;
  step_t attack_step;
  step_t release_step;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= 1'b0;
      attack_step  <= STEP_RESET;
      release_step <= STEP_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_MODE:    mode         <= cfg_ch.data[0];
        CFG_ATTACK:  attack_step  <= cfg_ch.data;
        CFG_RELEASE: release_step <= cfg_ch.data;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  assign cfg.mode         = mode;
  assign cfg.attack_step  = attack_step;
  assign cfg.release_step = release_step;

endmodule

/* rtl/core/arenv_core.sv */
`timescale 1ns / 1ps
`include "linear_ar_asr_envelope_top_assert.svh"

module arenv_core (
  input  logic            clk,
  input  logic            rst,
  input  arenv_pkg::cfg_t cfg,
  arenv_in_if.sink        in_ch,
  arenv_out_if.source     out_ch
);
  import arenv_pkg::*;

  level_t  env_level;
  level_t  env_step;
  phase_t  env_phase;
  level_t  lvl_next;
  level_t  stp_next;
  phase_t  ph_next;
  level_t  sum_sat;
  logic [LEVEL_W:0] sum;
  level_t  atk;
  level_t  rel_neg;

  result_t out_d;
  logic    out_v;
  result_t sk_d;
  logic    sk_v;
  result_t res;
  logic    in_fire;
  logic    pop;

  assign atk     = level_t'({1'b0, cfg.attack_step});
  assign rel_neg = -level_t'({1'b0, cfg.release_step});

  // phase update, then add the step
  always_comb begin
    lvl_next = env_level;
    stp_next = env_step;
    ph_next  = env_phase;
    if (!cfg.mode) begin
      case (env_phase)
        PH_IDLE: begin
          if (in_ch.gate) begin
            stp_next = atk;
            ph_next  = PH_ATTACK;
          end
        end
        PH_ATTACK: begin
          if (env_level >= LEVEL_ONE) begin
            lvl_next = LEVEL_ONE;
            stp_next = '0;
            ph_next  = PH_SUSTAIN;
          end
        end
        PH_SUSTAIN: begin
          if (!in_ch.gate) begin
            stp_next = rel_neg;
            ph_next  = PH_RELEASE;
          end
        end
        default: begin
          if (env_level <= level_t'(0)) begin
            lvl_next = '0;
            stp_next = '0;
            ph_next  = PH_IDLE;
          end
        end
      endcase
    end else begin
      // AR: trigger restarts attack from any phase
      if (in_ch.gate) begin
        stp_next = atk;
        ph_next  = PH_ATTACK;
      end
      if (ph_next == PH_ATTACK) begin
        if (env_level >= LEVEL_ONE) begin
          lvl_next = LEVEL_ONE;
          stp_next = rel_neg;
          ph_next  = PH_RELEASE;
        end
      end else if (ph_next == PH_RELEASE) begin
        if (env_level <= level_t'(0)) begin
          lvl_next = '0;
          stp_next = '0;
          ph_next  = PH_IDLE;
        end
      end
    end
  end

  assign sum = {lvl_next[LEVEL_W-1], lvl_next} + {stp_next[LEVEL_W-1], stp_next};

  always_comb begin
    if (sum[LEVEL_W] != sum[LEVEL_W-1]) begin
      sum_sat = sum[LEVEL_W] ? LEVEL_MIN : LEVEL_MAX;
    end else begin
      sum_sat = sum[LEVEL_W-1:0];
    end
  end

  assign res.level = sum_sat;
  assign res.phase = ph_next;

  assign in_ch.ready = !sk_v;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign pop         = out_v && out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      env_level <= '0;
      env_step  <= '0;
      env_phase <= PH_IDLE;
    end else if (in_fire) begin
      env_level <= sum_sat;
      env_step  <= stp_next;
      env_phase <= ph_next;
    end
  end

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
      sk_v  <= 1'b0;
    end else if (!out_v || pop) begin
      if (sk_v) begin
        out_v <= 1'b1;
        sk_v  <= in_fire;
      end else begin
        out_v <= in_fire;
      end
    end else if (in_fire) begin
      sk_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v || pop) begin
      if (sk_v) begin
        out_d <= sk_d;
        sk_d  <= res;
      end else begin
        out_d <= res;
      end
    end else if (in_fire) begin
      sk_d <= res;
    end
  end

  assign out_ch.valid = out_v;
  assign out_ch.level = out_d.level;
  assign out_ch.phase = out_d.phase;

  `ARENV_ASSERT_NEVER(a_skid_without_out, clk, rst, sk_v && !out_v)
  `ARENV_ASSERT(a_sustain_full, clk, rst, (env_phase == PH_SUSTAIN) |-> (env_level == LEVEL_ONE && env_step == level_t'(0)))
  `ARENV_ASSERT(a_idle_no_step, clk, rst, (env_phase == PH_IDLE) |-> (env_step == level_t'(0)))
  `ARENV_ASSERT(a_stall_fills_skid, clk, rst, (in_fire && out_v && !out_ch.ready) |=> sk_v)

endmodule

/* rtl/core/linear_ar_asr_envelope_top.sv */
`timescale 1ns / 1ps
// Linear AR/ASR envelope generator, one gate sample in, one level sample out.
// Channels (valid/ready, a transaction when both are high on a rising edge):
//   in_ch  : gate bit per sample tick (gate level in ASR, trigger in AR)
//   out_ch : level (signed Q2.24) and phase (idle/attack/sustain/release)
//   cfg_ch : register writes, index 0 mode, 1 attack_step, 2 release_step;
//            always ready, other indexes ignored. Write only while idle.
// Results are registered. Throughput: one sample per cycle while out_ch is
// not stalled; the phase/level update is a compare, clamp and one 27-bit
// saturating add between the state registers.
// The output side is a result register plus one skid entry, so an input is
// still taken while a result waits. If the receiver stalls, the skid entry
// fills and in_ch.ready drops until the receiver takes a result.
// Reset (rst, synchronous, active high): level and step 0, phase idle,
// mode ASR, both steps 349; output and skid empty.
module linear_ar_asr_envelope_top (
  input  logic        clk,
  input  logic        rst,
  arenv_in_if.sink    in_ch,
  arenv_out_if.source out_ch,
  arenv_cfg_if.sink   cfg_ch
);
  import arenv_pkg::*;

  // live register values
  cfg_t cfg;

  arenv_cfg u_cfg (
    .clk    (clk),
    .rst    (rst),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // envelope state, update logic and output buffering
  arenv_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
